[rtl/rwsa_pkg.sv]
// ----------------------------------------------------------------------------
// rwsa_pkg: shared types and constants
// Widths, fixed-point constants and the queue item type of the weighted
// residual sum accumulator.
// ----------------------------------------------------------------------------
package rwsa_pkg;

    localparam int SAMPLE_W  = 32;   // raw sample width
    localparam int FRAC_W    = 16;   // fraction bits of samples and sum
    localparam int SUM_W     = 64;   // accumulator width
    localparam int LOG2_FRAC = 28;   // fraction bits of the log2 value
    localparam int ROOT_W    = (SAMPLE_W + FRAC_W) / 2;  // square root width
    localparam int WGT_W     = ROOT_W + 1;               // weight = root + one
    localparam int REM_W     = ROOT_W + 2;               // shared remainder
    localparam int OP_W      = SAMPLE_W + FRAC_W;        // radicand / dividend
    localparam int TERM_W    = 2 * SAMPLE_W - FRAC_W;    // squared quotient
    localparam int LOGM_W    = 19;   // magnitude of a base-10 log in QF
    localparam int MUL_W     = 33;   // shared multiplier operand width
    localparam int CNT_W     = 6;

    localparam logic [MUL_W-1:0] LOG10_2_Q30 = 33'd323228497;
    localparam logic [WGT_W-1:0] FIX_ONE     = WGT_W'(1) << FRAC_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // What the back end has to do with a queued pair.
    typedef enum logic [1:0] {
        KIND_SKIP   = 2'd0,  // masked pair, adds nothing
        KIND_DOMAIN = 2'd1,  // log mode with a zero sample
        KIND_LIN    = 2'd2,  // linear residual
        KIND_LOG    = 2'd3   // log residual
    } rwsa_kind_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] f;
        logic [SAMPLE_W-1:0] g;
        rwsa_kind_t          kind;
        logic                last;
    } rwsa_item_t;

endpackage

[rtl/rwsa_ifs.sv]
// ----------------------------------------------------------------------------
// rwsa_ifs: channel interfaces
// Sample, configuration and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rwsa_smp_if import rwsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] measured_value;
    logic [SAMPLE_W-1:0] model_value;
    logic                masked_flag;
    logic                last_pair;

    modport source (output valid, measured_value, model_value, masked_flag,
                     last_pair, input ready);
    modport sink   (input valid, measured_value, model_value, masked_flag,
                     last_pair, output ready);
endinterface

interface rwsa_cfg_if ();
    logic valid;
    logic ready;
    logic log_scale;

    modport source (output valid, log_scale, input ready);
    modport sink   (input valid, log_scale, output ready);
endinterface

interface rwsa_res_if import rwsa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] residual_sum;
    logic             saturated;
    logic             domain_error;

    modport source (output valid, residual_sum, saturated, domain_error,
                     input ready);
    modport sink   (input valid, residual_sum, saturated, domain_error,
                     output ready);
endinterface

[rtl/rwsa_front.sv]
// ----------------------------------------------------------------------------
// rwsa_front: request intake and classification
// Holds the mode register and sorts each sample request into the work the
// back end must do.
// ----------------------------------------------------------------------------
module rwsa_front import rwsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rwsa_smp_if.sink    smp,
    rwsa_cfg_if.sink    cfg,
    input  logic        q_full,
    output logic        push,
    output rwsa_item_t  push_item
);

    logic log_scale_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_scale_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            log_scale_reg <= cfg.log_scale;
        end
    end

    assign smp.ready = !q_full;
    assign push      = smp.valid && !q_full;

    always_comb
    begin
        push_item.f    = smp.measured_value;
        push_item.g    = smp.model_value;
        push_item.last = smp.last_pair;
        if (smp.masked_flag)
        begin
            push_item.kind = KIND_SKIP;
        end
        else if (log_scale_reg)
        begin
            // The log of zero is undefined: flag it and add nothing.
            if (smp.measured_value == '0 || smp.model_value == '0)
            begin
                push_item.kind = KIND_DOMAIN;
            end
            else
            begin
                push_item.kind = KIND_LOG;
            end
        end
        else
        begin
            push_item.kind = KIND_LIN;
        end
    end

endmodule

[rtl/rwsa_queue.sv]
// ----------------------------------------------------------------------------
// rwsa_queue: item queue
// Short FIFO between the intake and the arithmetic engine.
// ----------------------------------------------------------------------------
module rwsa_queue import rwsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rwsa_item_t  push_item,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output rwsa_item_t  head_item
);

    rwsa_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/rwsa_back.sv]
// ----------------------------------------------------------------------------
// rwsa_back: arithmetic engine
// Sequencer around one shared multiplier and a shift-subtract step that
// computes logs, the square root weight, the quotient and the running sum.
// ----------------------------------------------------------------------------
module rwsa_back import rwsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  rwsa_item_t  head_item,
    output logic        pop,
    rwsa_res_if.source  res
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_NORM   = 11'b00000000010,
        S_LOGSQ  = 11'b00000000100,
        S_LOGMAG = 11'b00000001000,
        S_LOGSCL = 11'b00000010000,
        S_DIFF   = 11'b00000100000,
        S_SQRT   = 11'b00001000000,
        S_DIVSET = 11'b00010000000,
        S_DIV    = 11'b00100000000,
        S_SQUARE = 11'b01000000000,
        S_EMIT   = 11'b10000000000
    } state_t;

    // Accumulation happens in S_IDLE while acc_pending_reg is set.
    state_t                state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [SAMPLE_W-1:0]   x_reg;
    logic [4:0]            sh_reg;
    logic [LOG2_FRAC-1:0]  frac_reg;
    logic [OP_W-1:0]       op_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [WGT_W-1:0]      w_reg;
    logic [SAMPLE_W-1:0]   q_reg;
    logic [SAMPLE_W-1:0]   d_reg;
    logic [SAMPLE_W-1:0]   g_hold_reg;
    logic                  phase_reg;
    logic                  a_neg_reg;
    logic [LOGM_W-1:0]     a_mag_reg;
    logic                  b_neg_reg;
    logic [LOGM_W-1:0]     b_mag_reg;
    logic [TERM_W-1:0]     term_reg;
    logic                  acc_pending_reg;
    logic                  last_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic                  sat_reg;
    logic                  dom_reg;
    logic                  out_valid_reg;
    logic [SUM_W-1:0]      out_sum_reg;
    logic                  out_sat_reg;
    logic                  out_dom_reg;

    logic [MUL_W-1:0]      mul_a;
    logic [MUL_W-1:0]      mul_b;
    logic [2*MUL_W-1:0]    mul_p;
    logic [4:0]            norm_amt;
    logic [SAMPLE_W-1:0]   norm_mask;
    logic [SAMPLE_W:0]     sq_t;
    logic [MUL_W-1:0]      log_mag;
    logic [MUL_W-1:0]      int_part;
    logic signed [LOGM_W+1:0] av;
    logic signed [LOGM_W+1:0] bv;
    logic signed [LOGM_W+1:0] dv;
    logic [REM_W+1:0]      sq_rem;
    logic [REM_W-1:0]      sq_trial;
    logic [REM_W:0]        div_rem;
    logic [SUM_W:0]        acc_sum;
    logic                  out_free;

    assign out_free = !out_valid_reg || res.ready;
    assign pop      = (state_reg == S_IDLE) && !acc_pending_reg && head_valid;

    // Shared multiplier: log squaring, log10 scaling and the final square.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_LOGSQ)
        begin
            mul_a = {1'b0, x_reg};
            mul_b = {1'b0, x_reg};
        end
        else if (state_reg == S_LOGSCL)
        begin
            mul_a = op_reg[MUL_W-1:0];
            mul_b = LOG10_2_Q30;
        end
        else if (state_reg == S_SQUARE)
        begin
            mul_a = {1'b0, q_reg};
            mul_b = {1'b0, q_reg};
        end
        mul_p = mul_a * mul_b;
    end

    // Binary normalize search: 16, 8, 4, 2, 1 bit steps.
    always_comb
    begin
        case (cnt_reg[2:0])
            3'd0:    norm_amt = 5'd16;
            3'd1:    norm_amt = 5'd8;
            3'd2:    norm_amt = 5'd4;
            3'd3:    norm_amt = 5'd2;
            default: norm_amt = 5'd1;
        endcase
        norm_mask = ~({SAMPLE_W{1'b1}} >> norm_amt);
    end

    always_comb
    begin
        sq_t = mul_p[2*SAMPLE_W-1:SAMPLE_W-1];
        if (sh_reg <= 5'd15)
        begin
            int_part = {5'd15 - sh_reg, {LOG2_FRAC{1'b0}}};
            log_mag  = int_part + {5'b0, frac_reg};
        end
        else
        begin
            int_part = {sh_reg - 5'd15, {LOG2_FRAC{1'b0}}};
            log_mag  = int_part - {5'b0, frac_reg};
        end
        av = a_neg_reg ? -$signed({2'b0, a_mag_reg}) : $signed({2'b0, a_mag_reg});
        bv = b_neg_reg ? -$signed({2'b0, b_mag_reg}) : $signed({2'b0, b_mag_reg});
        dv = av - bv;
        if (dv < 0)
        begin
            dv = -dv;
        end
        sq_rem   = {rem_reg, op_reg[OP_W-1 -: 2]};
        sq_trial = {root_reg, 2'b01};
        div_rem  = {rem_reg, op_reg[OP_W-1]};
        acc_sum  = {1'b0, sum_reg} + {{(SUM_W+1-TERM_W){1'b0}}, term_reg};
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    last_reg <= head_item.last;
                    term_reg <= '0;
                    root_reg <= '0;
                    rem_reg  <= '0;
                    sh_reg   <= '0;
                    phase_reg <= 1'b0;
                    x_reg    <= head_item.f;
                    g_hold_reg <= head_item.g;
                    op_reg   <= {head_item.f, {FRAC_W{1'b0}}};
                    d_reg    <= (head_item.f > head_item.g) ?
                                head_item.f - head_item.g : head_item.g - head_item.f;
                end
            end
            S_NORM:
            begin
                if ((x_reg & norm_mask) == '0)
                begin
                    x_reg  <= x_reg << norm_amt;
                    sh_reg <= sh_reg + norm_amt;
                end
            end
            S_LOGSQ:
            begin
                if (sq_t[SAMPLE_W])
                begin
                    x_reg    <= sq_t[SAMPLE_W:1];
                    frac_reg <= {frac_reg[LOG2_FRAC-2:0], 1'b1};
                end
                else
                begin
                    x_reg    <= sq_t[SAMPLE_W-1:0];
                    frac_reg <= {frac_reg[LOG2_FRAC-2:0], 1'b0};
                end
            end
            S_LOGMAG:
            begin
                op_reg <= {{(OP_W-MUL_W){1'b0}}, log_mag};
            end
            S_LOGSCL:
            begin
                if (!phase_reg)
                begin
                    a_neg_reg <= (sh_reg > 5'd15);
                    a_mag_reg <= mul_p[LOG2_FRAC+30-FRAC_W +: LOGM_W];
                    x_reg     <= g_hold_reg;
                    sh_reg    <= '0;
                    phase_reg <= 1'b1;
                end
                else
                begin
                    b_neg_reg <= (sh_reg > 5'd15);
                    b_mag_reg <= mul_p[LOG2_FRAC+30-FRAC_W +: LOGM_W];
                end
            end
            S_DIFF:
            begin
                d_reg    <= {{(SAMPLE_W-LOGM_W-1){1'b0}}, dv[LOGM_W:0]};
                op_reg   <= {{(SAMPLE_W-LOGM_W){1'b0}}, a_mag_reg, {FRAC_W{1'b0}}};
                root_reg <= '0;
                rem_reg  <= '0;
            end
            S_SQRT:
            begin
                op_reg <= op_reg << 2;
                if (sq_rem >= {2'b0, sq_trial})
                begin
                    rem_reg  <= REM_W'(sq_rem - {2'b0, sq_trial});
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= sq_rem[REM_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            S_DIVSET:
            begin
                w_reg   <= {1'b0, root_reg} + FIX_ONE;
                rem_reg <= {{(REM_W-FRAC_W){1'b0}}, d_reg[SAMPLE_W-1:FRAC_W]};
                op_reg  <= {d_reg[FRAC_W-1:0], {(OP_W-FRAC_W){1'b0}}};
            end
            S_DIV:
            begin
                op_reg <= op_reg << 1;
                if (div_rem >= {2'b0, w_reg})
                begin
                    rem_reg <= REM_W'(div_rem - {2'b0, w_reg});
                    q_reg   <= {q_reg[SAMPLE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_rem[REM_W-1:0];
                    q_reg   <= {q_reg[SAMPLE_W-2:0], 1'b0};
                end
            end
            S_SQUARE:
            begin
                term_reg <= mul_p[2*SAMPLE_W-1:FRAC_W];
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_sum_reg <= sum_reg;
                    out_sat_reg <= sat_reg;
                    out_dom_reg <= dom_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control: state, counters, accumulator and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            acc_pending_reg <= 1'b0;
            sum_reg         <= '0;
            sat_reg         <= 1'b0;
            dom_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // A sum taken by the receiver frees the result register, unless a
            // new sum is loaded into it at the same edge.
            if (res.ready && !((state_reg == S_EMIT) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc_pending_reg)
                    begin
                        // Add the finished term; a carry out clamps the sum.
                        acc_pending_reg <= 1'b0;
                        if (acc_sum[SUM_W])
                        begin
                            sum_reg <= '1;
                            sat_reg <= 1'b1;
                        end
                        else
                        begin
                            sum_reg <= acc_sum[SUM_W-1:0];
                        end
                        if (last_reg)
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                    else if (pop)
                    begin
                        cnt_reg <= '0;
                        case (head_item.kind)
                            KIND_LIN:    state_reg <= S_SQRT;
                            KIND_LOG:    state_reg <= S_NORM;
                            KIND_DOMAIN:
                            begin
                                dom_reg         <= 1'b1;
                                acc_pending_reg <= 1'b1;
                            end
                            default:     acc_pending_reg <= 1'b1;
                        endcase
                    end
                end
                S_NORM:
                begin
                    if (cnt_reg == CNT_W'(4))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_LOGSQ;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_LOGSQ:
                begin
                    if (cnt_reg == CNT_W'(LOG2_FRAC - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_LOGMAG;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_LOGMAG:
                begin
                    state_reg <= S_LOGSCL;
                end
                S_LOGSCL:
                begin
                    state_reg <= phase_reg ? S_DIFF : S_NORM;
                end
                S_DIFF:
                begin
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (cnt_reg == CNT_W'(ROOT_W - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DIVSET;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DIVSET:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == CNT_W'(SAMPLE_W - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SQUARE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SQUARE:
                begin
                    acc_pending_reg <= 1'b1;
                    state_reg       <= S_IDLE;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        sum_reg       <= '0;
                        sat_reg       <= 1'b0;
                        dom_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.residual_sum = out_sum_reg;
    assign res.saturated    = out_sat_reg;
    assign res.domain_error = out_dom_reg;

endmodule

[rtl/weighted_residual_sum_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// weighted_residual_sum_accumulator_unit: weighted sum of squared residuals
// Streams measured/model sample pairs and returns the saturating weighted
// residual sum with its flags on the last pair of each data set.
// ----------------------------------------------------------------------------
//
//  Channel     Dir  Payload                                          Request
//  sample_ch   in   measured_value, model_value, masked_flag,        one pair
//                   last_pair
//  config_ch   in   log_scale                                        mode write
//  result_ch   out  residual_sum, saturated, domain_error            one sum
//
//  The engine runs a 24-step square root and a 32-step divide, one bit per
//  cycle, plus for log mode two 5-step normalizations and two 28-step
//  squaring loops on the one shared 33x33 multiplier.
//  rst_n clears the mode register, the queue, the sum and both flags at once.
//  The two-entry queue keeps sample_ch ready until two pairs wait in it, and
//  the result register lets the engine run on while a sum waits on result_ch.
//
// ----------------------------------------------------------------------------
module weighted_residual_sum_accumulator_unit import rwsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rwsa_smp_if.sink    sample_ch,
    rwsa_cfg_if.sink    config_ch,
    rwsa_res_if.source  result_ch
);

    logic       q_full;
    logic       push;
    rwsa_item_t push_item;
    logic       pop;
    logic       head_valid;
    rwsa_item_t head_item;

    // Intake: the mode is sampled with each pair, so a pair carries its own
    // classification through the queue.
    rwsa_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp       (sample_ch),
        .cfg       (config_ch),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    rwsa_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Engine: one pair at a time, accumulates and emits on the last pair.
    rwsa_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .res        (result_ch)
    );

endmodule
